[sv/nfc_host_frame_encoder_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the frame encoder RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef NFC_HOST_FRAME_ENCODER_UNIT_ASSERT_SVH
`define NFC_HOST_FRAME_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NFC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame encoder assertion failed");

// Next-cycle implication, checked outside reset.
`define NFC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame encoder assertion failed");

`endif

[sv/nfc_fe_pkg.sv]
// ----------------------------------------------------------------------------
// nfc_fe_pkg
// Types and constants shared by the host frame encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfc_fe_pkg;

    // Frame byte constants.
    localparam logic [7:0] DIR_HOST   = 8'hD4;
    localparam logic [7:0] START_CODE = 8'hFF;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    // Input word kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Input word.
    typedef struct packed {
        logic       kind;
        logic [7:0] payload_count;
        logic [7:0] data_byte;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_done;
        logic       sequence_error;
    } out_word_t;

    // Command classes passed from front to back.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_LAST  = 2'd2,
        OP_ERROR = 2'd3
    } cmd_op_t;

    // One queued command: op plus the two bytes it needs.
    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] arg_a;   // LEN for start, payload byte for byte and last
        logic [7:0] arg_b;   // data checksum for last
    } cmd_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

[sv/nfc_fe_front.sv]
// ----------------------------------------------------------------------------
// nfc_fe_front
// Accepts input words, checks their order, tracks frame state and the
// running data sum, and pushes one command per word into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nfc_host_frame_encoder_unit_assert.svh"

module nfc_fe_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  nfc_fe_pkg::in_word_t  in_data,
    input  nfc_fe_pkg::q_status_t q_status,
    output logic                  push,
    output nfc_fe_pkg::cmd_t      push_cmd
);

    logic       in_frame_reg,    in_frame_next;
    logic [7:0] bytes_left_reg,  bytes_left_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] sum_add;
    logic [7:0] left_dec;

    // Accept whenever the queue has room.
    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    assign sum_add  = running_sum_reg + in_data.data_byte;
    assign left_dec = bytes_left_reg - 8'd1;

    // Classify the word and work out the next frame state.
    always_comb
    begin
        in_frame_next    = in_frame_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        push_cmd.op      = nfc_fe_pkg::OP_ERROR;
        push_cmd.arg_a   = nfc_fe_pkg::ZERO_BYTE;
        push_cmd.arg_b   = nfc_fe_pkg::ZERO_BYTE;
        if (in_data.kind == nfc_fe_pkg::KIND_START)
        begin
            if (!in_frame_reg && (in_data.payload_count != 8'd0))
            begin
                push_cmd.op      = nfc_fe_pkg::OP_START;
                push_cmd.arg_a   = in_data.payload_count + 8'd1;
                in_frame_next    = 1'b1;
                bytes_left_next  = in_data.payload_count;
                running_sum_next = nfc_fe_pkg::DIR_HOST;
            end
        end
        else if (in_frame_reg)
        begin
            push_cmd.arg_a   = in_data.data_byte;
            running_sum_next = sum_add;
            bytes_left_next  = left_dec;
            if (left_dec != 8'd0)
            begin
                push_cmd.op = nfc_fe_pkg::OP_BYTE;
            end
            else
            begin
                push_cmd.op    = nfc_fe_pkg::OP_LAST;
                push_cmd.arg_b = 8'd0 - sum_add;
                in_frame_next  = 1'b0;
            end
        end
    end

    // Frame state registers, updated on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            bytes_left_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
        end
        else if (push)
        begin
            in_frame_reg    <= in_frame_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

    // An open frame always has bytes to come; a closed one has none.
    `NFC_ASSERT_IMP(a_open_has_bytes, in_frame_reg, bytes_left_reg != 8'd0)
    `NFC_ASSERT_IMP(a_idle_no_bytes, !in_frame_reg, bytes_left_reg == 8'd0)

endmodule

[sv/nfc_fe_queue.sv]
// ----------------------------------------------------------------------------
// nfc_fe_queue
// Small register queue of commands between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nfc_host_frame_encoder_unit_assert.svh"

module nfc_fe_queue #(
    parameter int DEPTH = nfc_fe_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  nfc_fe_pkg::cmd_t      push_cmd,
    input  logic                  pop,
    output nfc_fe_pkg::cmd_t      head_cmd,
    output nfc_fe_pkg::q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nfc_fe_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign head_cmd           = entry_reg[rd_ptr_reg];
    assign q_status.not_empty = (count_reg != '0);
    assign q_status.full      = (count_reg == CNT_W'(DEPTH));

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // No write into a full queue and no read from an empty one.
    `NFC_ASSERT_IMP(a_no_overflow, push, count_reg != CNT_W'(DEPTH))
    `NFC_ASSERT_IMP(a_no_underflow, pop, count_reg != '0)

endmodule

[sv/nfc_fe_back.sv]
// ----------------------------------------------------------------------------
// nfc_fe_back
// Expands queued commands into framed output bytes, one per cycle unless the
// output stalls or the queue is empty, into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nfc_host_frame_encoder_unit_assert.svh"

module nfc_fe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nfc_fe_pkg::cmd_t      head_cmd,
    input  nfc_fe_pkg::q_status_t q_status,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output nfc_fe_pkg::out_word_t out_data
);

    nfc_fe_pkg::cmd_t      cmd_reg,       cmd_next;
    logic                  busy_reg,      busy_next;
    logic [2:0]            step_reg,      step_next;
    logic                  out_valid_reg, out_valid_next;
    nfc_fe_pkg::out_word_t out_word_reg,  out_word_next;

    nfc_fe_pkg::cmd_t      cur_cmd;
    logic                  have_cmd;
    logic                  fire;
    logic                  last_step;
    nfc_fe_pkg::out_word_t gen_word;

    // Work on the held command, or straight from the queue head.
    assign cur_cmd  = busy_reg ? cmd_reg : head_cmd;
    assign have_cmd = busy_reg || q_status.not_empty;
    assign fire     = have_cmd && (!out_valid_reg || out_ready);
    assign pop      = fire && !busy_reg;

    // Byte generator: one output word per step of the command.
    always_comb
    begin
        gen_word  = '0;
        last_step = 1'b1;
        unique case (cur_cmd.op)
            nfc_fe_pkg::OP_START:
            begin
                last_step = (step_reg == 3'd5);
                case (step_reg)
                    3'd0, 3'd1: gen_word.out_byte = nfc_fe_pkg::ZERO_BYTE;
                    3'd2:       gen_word.out_byte = nfc_fe_pkg::START_CODE;
                    3'd3:       gen_word.out_byte = cur_cmd.arg_a;
                    3'd4:       gen_word.out_byte = 8'd0 - cur_cmd.arg_a;
                    default:    gen_word.out_byte = nfc_fe_pkg::DIR_HOST;
                endcase
                gen_word.last_of_run = last_step;
            end
            nfc_fe_pkg::OP_BYTE:
            begin
                gen_word.out_byte    = cur_cmd.arg_a;
                gen_word.last_of_run = 1'b1;
            end
            nfc_fe_pkg::OP_LAST:
            begin
                last_step = (step_reg == 3'd2);
                case (step_reg)
                    3'd0:    gen_word.out_byte = cur_cmd.arg_a;
                    3'd1:    gen_word.out_byte = cur_cmd.arg_b;
                    default: gen_word.out_byte = nfc_fe_pkg::ZERO_BYTE;
                endcase
                gen_word.last_of_run = last_step;
                gen_word.frame_done  = last_step;
            end
            default:
            begin
                gen_word.out_byte       = nfc_fe_pkg::ZERO_BYTE;
                gen_word.last_of_run    = 1'b1;
                gen_word.sequence_error = 1'b1;
            end
        endcase
    end

    // Step sequencing and output stage update.
    always_comb
    begin
        cmd_next       = cmd_reg;
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_word_next  = gen_word;
            if (last_step)
            begin
                busy_next = 1'b0;
                step_next = 3'd0;
            end
            else
            begin
                busy_next = 1'b1;
                step_next = step_reg + 3'd1;
                if (!busy_reg)
                begin
                    cmd_next = head_cmd;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // Step counter is nonzero exactly while a command is held.
    `NFC_ASSERT_IMP(a_busy_step, busy_reg, step_reg != 3'd0)
    `NFC_ASSERT_IMP(a_idle_step, !busy_reg, step_reg == 3'd0)
    // An error word carries a zero byte and ends its run.
    `NFC_ASSERT_IMP(a_err_word, out_valid_reg && out_word_reg.sequence_error,
                    out_word_reg.out_byte == 8'd0 && out_word_reg.last_of_run)

endmodule

[sv/nfc_host_frame_encoder_unit.sv]
// ----------------------------------------------------------------------------
// nfc_host_frame_encoder_unit
// Wraps host command payloads in NFC controller information frames.
//
//   Channel  Direction  Handshake           Word
//   in       input      in_valid/in_ready   in_word_t (kind, count, data byte)
//   out      output     out_valid/out_ready out_word_t (byte and flags)
//
// The front accepts one input word per cycle while the command queue has room.
// The back emits one framed byte per cycle unless stalled by out_ready or an
// empty queue: a start word gives 6 bytes, a payload byte 1, the last payload
// byte 3 and a rejected word 1, so the input rate follows each word's bytes.
// Reset clears frame state, queue pointers and the output valid flag.
// Output stalls back up into the queue and then drop in_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfc_host_frame_encoder_unit #(
    parameter int QUEUE_DEPTH = nfc_fe_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  nfc_fe_pkg::in_word_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output nfc_fe_pkg::out_word_t out_data
);

    nfc_fe_pkg::q_status_t q_status;
    nfc_fe_pkg::cmd_t      push_cmd;
    nfc_fe_pkg::cmd_t      head_cmd;
    logic                  push;
    logic                  pop;

    // Front: order checking and frame state.
    nfc_fe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue between front and back.
    nfc_fe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    // Back: byte sequencing and output register.
    nfc_fe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: frame encoder testbench
// Sends start and payload byte words into the frame encoder with random gaps
// and random output stalls. A local model of the framing rules predicts every
// framed byte, and a monitor checks each output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_WORDS = 150;
    localparam int MAX_REPORTS  = 10;
    localparam int TAIL_CYCLES  = 80;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    nfc_fe_pkg::in_word_t  in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    nfc_fe_pkg::out_word_t out_data;

    // Words waiting to be driven, and framed bytes waiting to be seen.
    nfc_fe_pkg::in_word_t  words_to_send[$];
    nfc_fe_pkg::out_word_t expected_bytes[$];

    // Local copy of the encoder state.
    logic       frame_open = 1'b0;
    logic [7:0] bytes_owed = 8'd0;
    logic [7:0] data_sum   = 8'd0;

    int fail_count  = 0;
    int idle_cycles = 0;
    int send_gap    = 0;
    int recv_gap    = 0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    nfc_host_frame_encoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic nfc_fe_pkg::out_word_t framed(logic [7:0] b, logic last,
                                                     logic done, logic err);
        nfc_fe_pkg::out_word_t w;
        w.out_byte       = b;
        w.last_of_run    = last;
        w.frame_done     = done;
        w.sequence_error = err;
        return w;
    endfunction

    // Predict the framed bytes that one accepted word produces.
    task automatic encode_word(nfc_fe_pkg::in_word_t w);
        logic [7:0] len;
        len = w.payload_count + 8'd1;
        if (w.kind == nfc_fe_pkg::KIND_START)
        begin
            if (frame_open || w.payload_count == 8'd0)
            begin
                expected_bytes.push_back(framed(nfc_fe_pkg::ZERO_BYTE, 1'b1, 1'b0, 1'b1));
            end
            else
            begin
                expected_bytes.push_back(framed(nfc_fe_pkg::ZERO_BYTE, 1'b0, 1'b0, 1'b0));
                expected_bytes.push_back(framed(nfc_fe_pkg::ZERO_BYTE, 1'b0, 1'b0, 1'b0));
                expected_bytes.push_back(framed(nfc_fe_pkg::START_CODE, 1'b0, 1'b0, 1'b0));
                expected_bytes.push_back(framed(len, 1'b0, 1'b0, 1'b0));
                expected_bytes.push_back(framed(8'h00 - len, 1'b0, 1'b0, 1'b0));
                expected_bytes.push_back(framed(nfc_fe_pkg::DIR_HOST, 1'b1, 1'b0, 1'b0));
                frame_open = 1'b1;
                bytes_owed = w.payload_count;
                data_sum   = nfc_fe_pkg::DIR_HOST;
            end
        end
        else if (!frame_open)
        begin
            expected_bytes.push_back(framed(nfc_fe_pkg::ZERO_BYTE, 1'b1, 1'b0, 1'b1));
        end
        else
        begin
            data_sum   = data_sum + w.data_byte;
            bytes_owed = bytes_owed - 8'd1;
            if (bytes_owed != 8'd0)
            begin
                expected_bytes.push_back(framed(w.data_byte, 1'b1, 1'b0, 1'b0));
            end
            else
            begin
                expected_bytes.push_back(framed(w.data_byte, 1'b0, 1'b0, 1'b0));
                expected_bytes.push_back(framed(8'h00 - data_sum, 1'b0, 1'b0, 1'b0));
                expected_bytes.push_back(framed(nfc_fe_pkg::ZERO_BYTE, 1'b1, 1'b1, 1'b0));
                frame_open = 1'b0;
            end
        end
    endtask

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Unused fields carry random values so they are shown to be ignored.
    task automatic push_start(logic [7:0] cnt);
        nfc_fe_pkg::in_word_t w;
        w.kind          = nfc_fe_pkg::KIND_START;
        w.payload_count = cnt;
        w.data_byte     = 8'($urandom_range(0, 255));
        words_to_send.push_back(w);
    endtask

    task automatic push_byte(logic [7:0] b);
        nfc_fe_pkg::in_word_t w;
        w.kind          = nfc_fe_pkg::KIND_BYTE;
        w.payload_count = 8'($urandom_range(0, 255));
        w.data_byte     = b;
        words_to_send.push_back(w);
    endtask

    task automatic report_failure(string text);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, text);
    endtask

    // Driver: predicts each accepted word, then offers the next one after a gap.
    always @(posedge clk or negedge rst_n)
    begin
        bit take_next;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            take_next = 1'b1;
            if (in_valid && in_ready)
                encode_word(in_data);
            else if (in_valid)
                take_next = 1'b0;
            if (take_next)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (words_to_send.size() > 0)
                begin
                    in_data  <= words_to_send.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_steady = !send_steady;
                    send_gap = pick_gap(send_steady);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted output word and stalls the output at random.
    always @(posedge clk or negedge rst_n)
    begin
        nfc_fe_pkg::out_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_failure($sformatf("unexpected word byte=%h last=%b done=%b err=%b",
                        out_data.out_byte, out_data.last_of_run, out_data.frame_done,
                        out_data.sequence_error));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte
                            || out_data.last_of_run !== want.last_of_run
                            || out_data.frame_done !== want.frame_done
                            || out_data.sequence_error !== want.sequence_error)
                        report_failure($sformatf(
                            "mismatch exp byte=%h last=%b done=%b err=%b, got %h %b %b %b",
                            want.out_byte, want.last_of_run, want.frame_done,
                            want.sequence_error, out_data.out_byte, out_data.last_of_run,
                            out_data.frame_done, out_data.sequence_error));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    recv_steady = !recv_steady;
                recv_gap = pick_gap(recv_steady);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[nfc_host_frame_encoder_unit] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int count;
        int r;
        int sent;

        // Directed: wrong kinds while idle, zero count, smallest frames,
        // sum wrap and wrong kinds inside a frame.
        push_byte(8'hA5);
        push_start(8'd0);
        push_start(8'd1);
        push_byte(8'h00);
        push_start(8'd2);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_start(8'd3);
        push_byte(8'h5A);
        push_start(8'd5);
        push_start(8'd0);
        push_byte(8'h80);
        push_byte(8'h01);
        push_byte(8'hFF);
        push_start(8'd1);
        push_byte(8'h2C);

        // Random: mostly well-formed frames of short length, some noise.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 82)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    count = $urandom_range(1, 6);
                else if (r < 95)
                    count = $urandom_range(7, 24);
                else
                    count = $urandom_range(25, 60);
                push_start(8'(count));
                for (int i = 0; i < count; i++)
                begin
                    if ($urandom_range(0, 24) == 0)
                    begin
                        push_start(8'($urandom_range(0, 255)));
                        sent++;
                    end
                    push_byte(rand_data());
                end
                sent += count + 1;
            end
            else if (r < 91)
            begin
                push_byte(rand_data());
                sent++;
            end
            else
            begin
                push_start(8'd0);
                sent++;
            end
        end

        // The wrapping length: a frame of the largest count, left open.
        push_start(8'd255);
        for (int i = 0; i < 4; i++)
            push_byte(rand_data());

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for all words to go in and every framed byte to come out.
        while (words_to_send.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("[nfc_host_frame_encoder_unit] OK");
        else
            $display("[nfc_host_frame_encoder_unit] ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/nfc_fe_pkg.sv
sv/nfc_fe_front.sv
sv/nfc_fe_queue.sv
sv/nfc_fe_back.sv
sv/nfc_host_frame_encoder_unit.sv
bench/tb.sv
